FILE: rtl/stcp_pkg.sv
package stcp_pkg;

  localparam int CharW  = 8;
  localparam int ArgW   = 31;
  localparam int MaskW  = 24;
  localparam int CntW   = 4;
  localparam int DevW   = 5;
  localparam int EvW    = 4;
  localparam int ActW   = 2;
  localparam int CfgIdxW = 3;

  localparam logic [CntW-1:0]  ArgStart = 4'd7;
  localparam logic [CntW-1:0]  CntMax   = 4'd15;
  localparam logic [CharW-1:0] CrByte   = 8'd13;
  localparam logic [CharW-1:0] LetterR  = 8'h52;
  localparam logic [CharW-1:0] LetterT  = 8'h54;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDevIdx = 3'd0,
    CfgPlay   = 3'd1,
    CfgPause  = 3'd2,
    CfgResume = 3'd3,
    CfgStop   = 3'd4
  } cfg_idx_e;

  typedef enum logic [EvW-1:0] {
    EvRecall      = 4'd0,
    EvExecute     = 4'd1,
    EvIgnored     = 4'd2,
    EvShort       = 4'd3,
    EvBadDevice   = 4'd4,
    EvBadArg      = 4'd5,
    EvNoRegister  = 4'd6,
    EvBadTrigger  = 4'd7,
    EvUnsupported = 4'd8
  } event_e;

  typedef enum logic [ActW-1:0] {
    ActPlay   = 2'd0,
    ActPause  = 2'd1,
    ActResume = 2'd2,
    ActStop   = 2'd3
  } action_e;

  typedef struct packed {
    logic [DevW-1:0] dev_idx;
    logic [ArgW-1:0] play;
    logic [ArgW-1:0] pause;
    logic [ArgW-1:0] resume;
    logic [ArgW-1:0] stop;
  } cfg_t;

  typedef struct packed {
    event_e          ev;
    logic [ArgW-1:0] reg_num;
    action_e         act;
  } result_t;

  // msb set when the byte is not a hex digit
  function automatic logic [4:0] hex_decode(input logic [CharW-1:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/serial_trigger_command_parser.sv
// a carriage return beat passes the input register and then the result register
// throughput: one beat per cycle, one combinational pass between input and result registers
// a carriage return waits in the input register while the previous result is stalled,
// and the beats behind it wait with it
// reset: registers load their reset codes, line state clears, no register recalled
module serial_trigger_command_parser
  import stcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ArgW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CharW-1:0]   char_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [EvW-1:0]     event_res_o,
  output logic [ArgW-1:0]    register_number_o,
  output logic [ActW-1:0]    action_o
);

  cfg_t             cfg;
  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             is_cr;
  logic             adv;
  result_t          res;
  logic             out_vld_q;
  result_t          out_q;

  stcp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  stcp_line u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .char_i  (char_q),
    .cfg_i   (cfg),
    .is_cr_o (is_cr),
    .res_o   (res)
  );

  assign adv        = in_vld_q && (!is_cr || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv && is_cr) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
    if (adv && is_cr) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign event_res_o       = out_q.ev;
  assign register_number_o = out_q.reg_num;
  assign action_o          = out_q.act;

endmodule

FILE: rtl/stcp_cfg.sv
module stcp_cfg
  import stcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ArgW-1:0]    cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDevIdx: cfg_d.dev_idx = cfg_wdata_i[DevW-1:0];
        CfgPlay:   cfg_d.play    = cfg_wdata_i;
        CfgPause:  cfg_d.pause   = cfg_wdata_i;
        CfgResume: cfg_d.resume  = cfg_wdata_i;
        CfgStop:   cfg_d.stop    = cfg_wdata_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_idx <= '0;
      cfg_q.play    <= ArgW'(0);
      cfg_q.pause   <= ArgW'(1);
      cfg_q.resume  <= ArgW'(2);
      cfg_q.stop    <= ArgW'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/stcp_line.sv
module stcp_line
  import stcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  input  cfg_t             cfg_i,
  output logic             is_cr_o,
  output result_t          res_o
);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CharW-1:0] letter_q, letter_d;
  logic [MaskW-1:0] mask_q, mask_d;
  logic             dev_ok_q, dev_ok_d;
  logic [ArgW-1:0]  arg_q, arg_d;
  logic             arg_ok_q, arg_ok_d;
  logic             arg_seen_q, arg_seen_d;
  logic [ArgW-1:0]  rec_q, rec_d;
  logic             rec_vld_q, rec_vld_d;

  logic [4:0]  hex;
  logic [31:0] mask_ext;
  logic        addressed;

  assign hex      = hex_decode(char_i);
  assign is_cr_o  = (char_i == CrByte);
  assign mask_ext = {{(32-MaskW){1'b0}}, mask_q};
  assign addressed = mask_ext[cfg_i.dev_idx];

  // line verdict in check order
  always_comb begin
    res_o.ev      = EvUnsupported;
    res_o.reg_num = '0;
    res_o.act     = ActPlay;
    if (cnt_q < ArgStart) begin
      res_o.ev = EvShort;
    end else if (!dev_ok_q) begin
      res_o.ev = EvBadDevice;
    end else if (!addressed) begin
      res_o.ev = EvIgnored;
    end else if (!arg_ok_q || !arg_seen_q) begin
      res_o.ev = EvBadArg;
    end else if (letter_q == LetterR) begin
      res_o.ev      = EvRecall;
      res_o.reg_num = arg_q;
    end else if (letter_q == LetterT) begin
      if (!rec_vld_q) begin
        res_o.ev = EvNoRegister;
      end else begin
        res_o.ev      = EvExecute;
        res_o.reg_num = rec_q;
        if (arg_q == cfg_i.play) begin
          res_o.act = ActPlay;
        end else if (arg_q == cfg_i.pause) begin
          res_o.act = ActPause;
        end else if (arg_q == cfg_i.resume) begin
          res_o.act = ActResume;
        end else if (arg_q == cfg_i.stop) begin
          res_o.act = ActStop;
        end else begin
          res_o.ev      = EvBadTrigger;
          res_o.reg_num = '0;
        end
      end
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    letter_d   = letter_q;
    mask_d     = mask_q;
    dev_ok_d   = dev_ok_q;
    arg_d      = arg_q;
    arg_ok_d   = arg_ok_q;
    arg_seen_d = arg_seen_q;
    rec_d      = rec_q;
    rec_vld_d  = rec_vld_q;
    if (step_i) begin
      if (is_cr_o) begin
        cnt_d      = '0;
        letter_d   = '0;
        mask_d     = '0;
        dev_ok_d   = 1'b1;
        arg_d      = '0;
        arg_ok_d   = 1'b1;
        arg_seen_d = 1'b0;
        if (res_o.ev == EvRecall) begin
          rec_d     = arg_q;
          rec_vld_d = 1'b1;
        end
      end else begin
        if (cnt_q == '0) begin
          letter_d = char_i;
        end else if (cnt_q < ArgStart) begin
          if (hex[4]) begin
            dev_ok_d = 1'b0;
          end else begin
            mask_d = {mask_q[MaskW-5:0], hex[3:0]};
          end
        end else begin
          arg_seen_d = 1'b1;
          if (hex[4]) begin
            arg_ok_d = 1'b0;
          end else if (arg_ok_q) begin
            // shifting out a set bit means the value passed 31 bits
            if (arg_q[ArgW-1:ArgW-4] != 4'd0) begin
              arg_ok_d = 1'b0;
            end else begin
              arg_d = {arg_q[ArgW-5:0], hex[3:0]};
            end
          end
        end
        if (cnt_q != CntMax) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      letter_q   <= '0;
      mask_q     <= '0;
      dev_ok_q   <= 1'b1;
      arg_q      <= '0;
      arg_ok_q   <= 1'b1;
      arg_seen_q <= 1'b0;
      rec_q      <= '0;
      rec_vld_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      letter_q   <= letter_d;
      mask_q     <= mask_d;
      dev_ok_q   <= dev_ok_d;
      arg_q      <= arg_d;
      arg_ok_q   <= arg_ok_d;
      arg_seen_q <= arg_seen_d;
      rec_q      <= rec_d;
      rec_vld_q  <= rec_vld_d;
    end
  end

endmodule

FILE: verif/serial_trigger_command_parser_tb.sv
`timescale 1ns / 1ps

module serial_trigger_command_parser_tb;
  import stcp_pkg::*;

  localparam int StallMax = 14;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles = 4;
  localparam int PhaseChars = 300;
  localparam int SteadyChars = 400;
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;
  localparam logic [ArgW-1:0] ArgLimit = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ArgW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CharW-1:0]   char_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [EvW-1:0]     event_res_o;
  logic [ArgW-1:0]    register_number_o;
  logic [ActW-1:0]    action_o;

  // parser state as the block should hold it
  logic [DevW-1:0]  dev_idx;
  logic [ArgW-1:0]  code_play, code_pause, code_resume, code_stop;
  logic [CntW-1:0]  line_len;
  logic [CharW-1:0] cmd_letter;
  logic [MaskW-1:0] mask_acc;
  logic             mask_good, arg_good, arg_present;
  logic [ArgW-1:0]  arg_acc, recalled_reg;
  logic             recalled_valid;

  result_t          expected_events[$];
  logic [CharW-1:0] line_buf[$];
  int               errors = 0;
  int               chars_sent = 0;
  int               quiet_cycles = 0;
  int               stall_left = 0;
  bit               idling_on = 1'b1;

  serial_trigger_command_parser u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [4:0] hex_digit(input logic [CharW-1:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) return "0" + d;
    return (($urandom_range(0, 1) != 0) ? "a" : "A") + d - 8'd10;
  endfunction

  function automatic logic [CharW-1:0] random_byte();
    logic [CharW-1:0] b;
    do b = 8'($urandom); while (b == CrByte);
    return b;
  endfunction

  function automatic logic [ArgW-1:0] random_code();
    case ($urandom_range(0, 3))
      0: return 31'($urandom_range(0, 7));
      1: return 31'($urandom);
      2: return ArgLimit;
      default: return 31'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic void clear_line();
    line_len = '0;
    cmd_letter = '0;
    mask_acc = '0;
    mask_good = 1'b1;
    arg_acc = '0;
    arg_good = 1'b1;
    arg_present = 1'b0;
  endfunction

  task automatic predict_char(input logic [CharW-1:0] c);
    logic [4:0] d;
    logic [35:0] nv;
    result_t r;
    if (c == CrByte) begin
      r = '{ev: EvShort, reg_num: '0, act: ActPlay};
      if (line_len < ArgStart) r.ev = EvShort;
      else if (!mask_good) r.ev = EvBadDevice;
      else if (dev_idx > 5'd23 || !mask_acc[dev_idx]) r.ev = EvIgnored;
      else if (!arg_good || !arg_present) r.ev = EvBadArg;
      else if (cmd_letter == LetterR) begin
        recalled_reg = arg_acc;
        recalled_valid = 1'b1;
        r.ev = EvRecall;
        r.reg_num = arg_acc;
      end else if (cmd_letter == LetterT) begin
        if (!recalled_valid) r.ev = EvNoRegister;
        else begin
          r.ev = EvExecute;
          r.reg_num = recalled_reg;
          // first matching code wins when codes are equal
          if (arg_acc == code_play) r.act = ActPlay;
          else if (arg_acc == code_pause) r.act = ActPause;
          else if (arg_acc == code_resume) r.act = ActResume;
          else if (arg_acc == code_stop) r.act = ActStop;
          else begin
            r.ev = EvBadTrigger;
            r.reg_num = '0;
          end
        end
      end else r.ev = EvUnsupported;
      expected_events.push_back(r);
      clear_line();
    end else begin
      d = hex_digit(c);
      if (line_len == '0) cmd_letter = c;
      else if (line_len < ArgStart) begin
        if (d[4]) mask_good = 1'b0;
        else mask_acc = {mask_acc[MaskW-5:0], d[3:0]};
      end else begin
        arg_present = 1'b1;
        if (d[4]) arg_good = 1'b0;
        else if (arg_good) begin
          nv = {1'b0, arg_acc, d[3:0]};
          if (nv > 36'(ArgLimit)) arg_good = 1'b0;
          else arg_acc = nv[ArgW-1:0];
        end
      end
      if (line_len != CntMax) line_len = line_len + 1'b1;
    end
  endtask

  task automatic send_char(input logic [CharW-1:0] c);
    int gap;
    if (idling_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, StallMax);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    char_in_i = c;
    do @(posedge clk_i); while (!in_ready_o);
    predict_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    send_char(CrByte);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ArgW-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgDevIdx: dev_idx = val[DevW-1:0];
      CfgPlay:   code_play = val;
      CfgPause:  code_pause = val;
      CfgResume: code_resume = val;
      CfgStop:   code_stop = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic [DevW-1:0] dev, input logic [ArgW-1:0] p,
                              input logic [ArgW-1:0] pa, input logic [ArgW-1:0] rs,
                              input logic [ArgW-1:0] st);
    write_reg(CfgDevIdx, {{(ArgW-DevW){1'b0}}, dev});
    write_reg(CfgPlay, p);
    write_reg(CfgPause, pa);
    write_reg(CfgResume, rs);
    write_reg(CfgStop, st);
  endtask

  task automatic queue_command(input logic [CharW-1:0] letter, input logic [MaskW-1:0] mask,
                               input logic [35:0] arg, input int zeros);
    int ndig;
    line_buf.push_back(letter);
    for (int i = 5; i >= 0; i--) line_buf.push_back(hex_char(mask[4*i +: 4]));
    ndig = 1;
    for (int i = 1; i < 9; i++) if (arg[4*i +: 4] != 4'd0) ndig = i + 1;
    repeat (zeros) line_buf.push_back("0");
    for (int i = ndig - 1; i >= 0; i--) line_buf.push_back(hex_char(arg[4*i +: 4]));
  endtask

  task automatic random_line();
    int kind, pos;
    logic [CharW-1:0] letter;
    logic [MaskW-1:0] mask;
    logic [35:0] arg;
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: letter = LetterR;
        9: letter = random_byte();
        default: letter = LetterT;
      endcase
      mask = 24'($urandom);
      if (dev_idx <= 5'd23 && $urandom_range(0, 7) != 0) mask[dev_idx] = 1'b1;
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          case ($urandom_range(0, 3))
            0: arg = 36'(code_play);
            1: arg = 36'(code_pause);
            2: arg = 36'(code_resume);
            default: arg = 36'(code_stop);
          endcase
        end
        3: arg = 36'($urandom_range(0, 15));
        4: arg = 36'(31'($urandom));
        5: arg = 36'(ArgLimit);
        6: arg = {4'd0, 1'b1, 31'($urandom)};
        default: arg = {4'($urandom), 32'($urandom)};
      endcase
      queue_command(letter, mask, arg, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      // broken lines: one character replaced, or the line cut short
      if (kind >= 70) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        if (kind < 80) line_buf[pos] = random_byte();
        else while (line_buf.size() > pos) line_buf.delete(line_buf.size() - 1);
      end
    end else begin
      repeat ($urandom_range(0, 18)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    send_line();
  endtask

  task automatic test_directed_lines();
    send_text("T0000010");
    send_text("R00000");
    send_text("");
    send_text("R0000g11");
    send_text("R0000025");
    send_text("X000001g");
    send_text("R000001");
    send_text("R0000010x5");
    send_text("R000001 5");
    send_text("R000001-5");
    send_text("R00000180000000");
    send_text("R0000017fffffff");
    send_text("R000001000000000abc");
    send_text("T0000010");
    send_text("T0000011");
    send_text("T0000012");
    send_text("T0000013");
    send_text("T0000014");
    send_text("X0000015");
    send_text("R00\n0015");
    send_text("RABCDEF0000000A");
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_config(5'd23, ArgLimit, ArgLimit, '0, 31'd5);
    write_reg(CfgSpare, ArgLimit);
    send_text("R8000001");
    send_text("T8000007FFFFFFF");
    send_text("T8000000");
    send_text("T8000005");
    send_text("T7fffff0");
    wait_idle();
    write_config(5'd24, '0, '0, '0, '0);
    send_text("RFFFFFF1");
    wait_idle();
    write_config(5'd31, 31'd1, 31'd2, 31'd3, 31'd4);
    send_text("RFFFFFF1");
    send_text("TFFFFFF1");
    wait_idle();
  endtask

  task automatic random_phase(input int count);
    int target;
    target = chars_sent + count;
    write_config(($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
                                              : 5'($urandom_range(0, 23)),
                 random_code(), random_code(), random_code(), random_code());
    while (chars_sent < target) random_line();
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) random_phase(PhaseChars);
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    random_phase(SteadyChars);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_ready_i = 1'b0;
      stall_left = $urandom_range(1, StallMax) - 1;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, event %0d", $time, event_res_o);
      end else begin
        want = expected_events.pop_front();
        if (event_res_o !== want.ev) begin
          errors++;
          $display("%0t: event_res expected %0d actual %0d", $time, want.ev, event_res_o);
        end
        if (register_number_o !== want.reg_num) begin
          errors++;
          $display("%0t: register_number expected %0h actual %0h", $time, want.reg_num,
                   register_number_o);
        end
        if (action_o !== want.act) begin
          errors++;
          $display("%0t: action expected %0d actual %0d", $time, want.act, action_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    dev_idx = '0;
    code_play = 31'd0;
    code_pause = 31'd1;
    code_resume = 31'd2;
    code_stop = 31'd3;
    recalled_reg = '0;
    recalled_valid = 1'b0;
    clear_line();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_lines();
    test_config_extremes();
    test_random_traffic();
    test_steady_stream();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
